// ===== src/twhl_pkg.sv =====
// shared constants, types and codes for the tick window high/low block
package twhl_pkg;

  // tick store depth and derived widths
  localparam int DEPTH   = 64;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int TIME_W  = 48;
  localparam int PRICE_W = 32;
  localparam int WIN_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LOW     = 3'd3;

  // one stored tick
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  tick_time;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
  } entry_t;

  // controls from the sequencer to the scan unit
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctrl_t;

  // results of the scan unit
  typedef struct packed {
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    logic [CNT_W-1:0]   count;
  } scan_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== src/twhl_cell.sv =====
// one tick cell of the shifting store
module twhl_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  twhl_pkg::entry_t d,
  output twhl_pkg::entry_t q
);
  import twhl_pkg::*;

  // valid flag cleared at reset, tick payload follows the shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
    if (shift) begin
      q.tick_time <= d.tick_time;
      q.bid       <= d.bid;
      q.ask       <= d.ask;
    end
  end

endmodule

// ===== src/twhl_scan.sv =====
// scan unit at the wrap point: window eviction, high ask and low bid
module twhl_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  twhl_pkg::scan_ctrl_t         ctrl,
  input  logic [twhl_pkg::TIME_W-1:0]  tick_time,
  input  logic                         window_enable,
  input  logic [twhl_pkg::WIN_W-1:0]   window_ms,
  input  twhl_pkg::entry_t             wrap_in,
  output twhl_pkg::entry_t             wrap_out,
  output twhl_pkg::scan_stat_t         stat
);
  import twhl_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   count_inc;
  logic               evicting;
  logic [TIME_W-1:0]  cut;
  logic [PRICE_W-1:0] hi;
  logic [PRICE_W-1:0] lo;
  logic [TIME_W-1:0]  win_ext;
  logic               drop;

  assign win_ext   = {{(TIME_W-WIN_W){1'b0}}, window_ms};
  assign count_inc = (count == CNT_W'(DEPTH)) ? count : count + CNT_W'(1);

  // entry leaves the window while still at the front and not the last one
  assign drop = wrap_in.valid && evicting && (remaining > CNT_W'(1)) &&
                (wrap_in.tick_time < cut);

  always_comb begin
    wrap_out = wrap_in;
    if (drop) begin
      wrap_out.valid = 1'b0;
    end
  end

  // control state of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      evicting  <= 1'b0;
    end else if (ctrl.start) begin
      count     <= count_inc;
      remaining <= count_inc;
      evicting  <= window_enable && (tick_time >= win_ext);
    end else if (ctrl.step && wrap_in.valid) begin
      remaining <= remaining - CNT_W'(1);
      if (drop) begin
        count <= count - CNT_W'(1);
      end else begin
        evicting <= 1'b0;
      end
    end
  end

  // running extremes and cut-off time
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hi  <= '0;
      lo  <= '1;
      cut <= tick_time - win_ext;
    end else if (ctrl.step && wrap_in.valid && !drop) begin
      if (wrap_in.ask > hi) hi <= wrap_in.ask;
      if (wrap_in.bid < lo) lo <= wrap_in.bid;
    end
  end

  assign stat = '{hi: hi, lo: lo, count: count};

endmodule

// ===== src/tick_window_high_low_unit.sv =====
// top level of the tick window high/low block
//
// Input words carry one tick (tick_time, bid_price, ask_price) on in_valid /
// in_stall; result words carry highest_ask, lowest_bid, kept_count and
// overflow_drop on out_valid / out_stall. A word moves at a clock edge with
// valid high and stall low. Configuration is written on cfg_we with
// cfg_index and cfg_data, by the user only while the block is idle; the
// block itself does not enforce this. Ticks live in a row of cells with
// the newest in cell 0. On acceptance the row shifts by one and the new
// tick enters; a tick pushed out of the last cell is the overflow drop.
// The row then rotates through the scan unit at the wrap point, one cell a
// cycle, oldest tick first, which drops ticks behind the window and
// gathers the high ask and low bid. The result word is loaded into the
// output register when the rotation has ended and the register is free; the
// next tick is taken in the cycle after the result is loaded, so no tick
// is taken before the result of the last one is loaded.
// Reset empties the store, clears the trackers and configuration to zero and
// drops any waiting result. A stalled result holds the output register; the
// block then finishes its next tick and waits until the register frees.
module tick_window_high_low_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [twhl_pkg::TIME_W-1:0]         tick_time,
  input  logic [twhl_pkg::PRICE_W-1:0]        bid_price,
  input  logic [twhl_pkg::PRICE_W-1:0]        ask_price,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [twhl_pkg::PRICE_W-1:0]        highest_ask,
  output logic [twhl_pkg::PRICE_W-1:0]        lowest_bid,
  output logic [twhl_pkg::CNT_W-1:0]          kept_count,
  output logic                                overflow_drop,
  input  logic                                cfg_we,
  input  logic [twhl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twhl_pkg::CFG_W-1:0]          cfg_data
);
  import twhl_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  scan_cnt;
  logic              in_accept;
  logic              out_load;
  logic              dropped;
  logic              window_enable;
  logic [WIN_W-1:0]  window_ms;
  logic              track_high;
  logic              track_low;
  scan_ctrl_t        ctrl;
  scan_stat_t        stat;
  entry_t            new_entry;
  entry_t            wrap_back;
  entry_t            cell_d [DEPTH];
  entry_t            cell_q [DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_enable <= 1'b0;
      window_ms     <= '0;
      track_high    <= 1'b0;
      track_low     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_ENABLE: window_enable <= cfg_data[0];
        CFG_WINDOW_MS:     window_ms     <= cfg_data[WIN_W-1:0];
        CFG_TRACK_HIGH:    track_high    <= cfg_data[0];
        CFG_TRACK_LOW:     track_low     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    ctrl.step  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.step = 1'b1;
        if (scan_cnt == IDX_W'(DEPTH - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    ctrl.start = in_valid && !in_stall;
  end

  assign in_accept  = in_valid && !in_stall;

  // rotation step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (ctrl.step) begin
      scan_cnt <= (scan_cnt == IDX_W'(DEPTH - 1)) ? '0 : scan_cnt + IDX_W'(1);
    end
  end

  // overflow flag: last cell held a tick when the row shifted in a new one
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dropped <= cell_q[DEPTH-1].valid;
    end
  end

  // cell row: new tick enters on acceptance, scanned word wraps back on steps
  assign new_entry = '{valid: 1'b1, tick_time: tick_time, bid: bid_price,
                       ask: ask_price};

  always_comb begin
    cell_d[0] = in_accept ? new_entry : wrap_back;
    for (int i = 1; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i-1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    twhl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (in_accept || ctrl.step),
      .d     (cell_d[g]),
      .q     (cell_q[g])
    );
  end

  twhl_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .tick_time     (tick_time),
    .window_enable (window_enable),
    .window_ms     (window_ms),
    .wrap_in       (cell_q[DEPTH-1]),
    .wrap_out      (wrap_back),
    .stat          (stat)
  );

  // output register; tracker values live here and hold while disabled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      highest_ask <= '0;
      lowest_bid  <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      if (track_high) highest_ask <= stat.hi;
      if (track_low)  lowest_bid  <= stat.lo;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kept_count    <= stat.count;
      overflow_drop <= dropped;
    end
  end

  // checks
  a_kept_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kept_count != '0) && (kept_count <= CNT_W'(DEPTH)))
    else $error("kept_count out of range");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_SCAN) && (scan_cnt == '0))
    else $error("accepted tick did not start a scan");

  a_done_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (scan_cnt == '0))
    else $error("rotation ended off its starting place");

  a_newest_held: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (stat.count != '0)) |-> cell_q[0].valid)
    else $error("newest cell empty while ticks are held");

endmodule

// ===== tb/sv/twhl_result_check.sv =====
// result checker for the tick window high/low block: tracks the tick window and compares words
module twhl_result_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [twhl_pkg::TIME_W-1:0]    tick_time,
  input  logic [twhl_pkg::PRICE_W-1:0]   bid_price,
  input  logic [twhl_pkg::PRICE_W-1:0]   ask_price,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [twhl_pkg::PRICE_W-1:0]   highest_ask,
  input  logic [twhl_pkg::PRICE_W-1:0]   lowest_bid,
  input  logic [twhl_pkg::CNT_W-1:0]     kept_count,
  input  logic                           overflow_drop,
  input  logic                           cfg_we,
  input  logic [twhl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twhl_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             waiting,
  output int                             checked,
  output int                             drops
);
  timeunit 1ns;
  timeprecision 1ps;
  import twhl_pkg::*;

  // one result word
  typedef struct packed {
    logic [PRICE_W-1:0] ask_hi;
    logic [PRICE_W-1:0] bid_lo;
    logic [CNT_W-1:0]   kept;
    logic               drop;
  } hilo_word_t;

  // own copy of the tick ring, trackers and registers
  logic [TIME_W-1:0]  ring_time [DEPTH];
  logic [PRICE_W-1:0] ring_bid  [DEPTH];
  logic [PRICE_W-1:0] ring_ask  [DEPTH];
  int unsigned        oldest;
  int unsigned        held;
  logic [PRICE_W-1:0] high_hold;
  logic [PRICE_W-1:0] low_hold;
  logic               win_on;
  logic [WIN_W-1:0]   win_len;
  logic               high_on;
  logic               low_on;
  hilo_word_t         due_words [$];

  // append one tick, trim the window, rescan the kept ticks
  function automatic hilo_word_t track_tick(input logic [TIME_W-1:0] now,
                                            input logic [PRICE_W-1:0] bid,
                                            input logic [PRICE_W-1:0] ask);
    hilo_word_t         w;
    logic [TIME_W-1:0]  cut;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    int unsigned        slot;
    int unsigned        k;
    w.drop = 1'b0;
    // full ring loses its oldest tick
    if (held >= DEPTH) begin
      oldest = (oldest + 1) % DEPTH;
      held   = DEPTH - 1;
      w.drop = 1'b1;
    end
    slot = (oldest + held) % DEPTH;
    ring_time[slot] = now;
    ring_bid[slot]  = bid;
    ring_ask[slot]  = ask;
    held++;
    // window trim from the front, stops at the first tick inside the window
    if (win_on && now >= TIME_W'(win_len)) begin
      cut = now - TIME_W'(win_len);
      while (held > 1 && ring_time[oldest] < cut) begin
        oldest = (oldest + 1) % DEPTH;
        held--;
      end
    end
    hi = '0;
    lo = '1;
    for (k = 0; k < held; k++) begin
      slot = (oldest + k) % DEPTH;
      if (ring_ask[slot] > hi) hi = ring_ask[slot];
      if (ring_bid[slot] < lo) lo = ring_bid[slot];
    end
    if (high_on) high_hold = hi;
    if (low_on) low_hold = lo;
    w.ask_hi = high_hold;
    w.bid_lo = low_hold;
    w.kept   = CNT_W'(held);
    return w;
  endfunction

  // watch register writes and both channels at each edge
  always @(posedge clk) begin
    hilo_word_t due;
    hilo_word_t got;
    if (rst) begin
      oldest    = 0;
      held      = 0;
      high_hold = '0;
      low_hold  = '0;
      win_on    = 1'b0;
      win_len   = '0;
      high_on   = 1'b0;
      low_on    = 1'b0;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_ENABLE: win_on  = cfg_data[0];
          CFG_WINDOW_MS:     win_len = cfg_data[WIN_W-1:0];
          CFG_TRACK_HIGH:    high_on = cfg_data[0];
          CFG_TRACK_LOW:     low_on  = cfg_data[0];
          default: ;
        endcase
      end
      // result word against the oldest expectation
      if (out_valid && !out_stall) begin
        got = '{highest_ask, lowest_bid, kept_count, overflow_drop};
        if (due_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with none expected: ask %h bid %h kept %0d drop %0b",
                     $time, got.ask_hi, got.bid_lo, got.kept, got.drop);
        end else begin
          due = due_words.pop_front();
          if (got !== due) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result word %0d: highest_ask exp %h got %h, lowest_bid exp %h got %h",
                       $time, checked, due.ask_hi, got.ask_hi, due.bid_lo, got.bid_lo);
              $display("  kept_count exp %0d got %0d, overflow_drop exp %0b got %0b",
                       due.kept, got.kept, due.drop, got.drop);
            end
          end
          checked++;
          if (due.drop) drops++;
        end
      end
      // tick word taken: queue its result
      if (in_valid && !in_stall)
        due_words = {due_words, track_tick(tick_time, bid_price, ask_price)};
    end
    waiting = due_words.size();
  end

endmodule

// ===== tb/sv/tb_tick_window_high_low_unit.sv =====
// testbench top for the tick window high/low block: tick stimulus, idling and verdict
module tb_tick_window_high_low_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import twhl_pkg::*;

  localparam int RST_CYCLES = 12;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEGMENTS = 8;
  localparam int SEG_TICKS = 66;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    tick_time = '0;
  logic [PRICE_W-1:0]   bid_price = '0;
  logic [PRICE_W-1:0]   ask_price = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PRICE_W-1:0]   highest_ask;
  logic [PRICE_W-1:0]   lowest_bid;
  logic [CNT_W-1:0]     kept_count;
  logic                 overflow_drop;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int                   fault_count;
  int                   open_words;
  int                   checked_words;
  int                   drop_words;
  int unsigned          gap_pct = 0;
  int unsigned          stall_pct = 0;
  int                   ticks_sent = 0;
  int                   settings_used = 0;
  int                   quiet_cycles = 0;
  logic [TIME_W-1:0]    tape_ms = '0;

  tick_window_high_low_unit dut (.*);

  twhl_result_check hilo_check (
    .*,
    .errors  (fault_count),
    .waiting (open_words),
    .checked (checked_words),
    .drops   (drop_words)
  );

  always #4ns clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_tick_window_high_low_unit: errors");
      $finish;
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
      PACE_SEND: begin gap_pct = 77; stall_pct = 0;  end
      PACE_RECV: begin gap_pct = 0;  stall_pct = 77; end
      default:   begin gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // hold off the sender until every result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_words != 0);
  endtask

  // one-bit registers get random upper bits
  function automatic logic [CFG_W-1:0] flag_word(input logic on);
    logic [CFG_W-1:0] w;
    w = $urandom();
    w[0] = on;
    return w;
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // rewrite every register once the block is idle
  task automatic set_config(input logic en, input logic [WIN_W-1:0] ms,
                            input logic hi, input logic lo);
    wait_drained();
    put_reg(CFG_WINDOW_ENABLE, flag_word(en));
    put_reg(CFG_WINDOW_MS, CFG_W'(ms));
    put_reg(CFG_TRACK_HIGH, flag_word(hi));
    put_reg(CFG_TRACK_LOW, flag_word(lo));
    put_reg(CFG_SPARE, $urandom());
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // present one tick word and wait for it to be taken
  task automatic send_tick(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] bid,
                           input logic [PRICE_W-1:0] ask);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    tick_time <= t;
    bid_price <= bid;
    ask_price <= ask;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  function automatic logic [PRICE_W-1:0] pick_price();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom_range(0, 1000);
    return $urandom();
  endfunction

  // mostly forward steps, some out of order, a few long jumps
  function automatic void advance_tape(input int unsigned step_max);
    int unsigned d;
    int unsigned r;
    d = $urandom_range(0, step_max);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      if (tape_ms >= TIME_W'(d)) tape_ms = tape_ms - TIME_W'(d);
    end else if (r < 10) begin
      tape_ms = tape_ms + TIME_W'(step_max) * 8;
    end else begin
      tape_ms = tape_ms + TIME_W'(d);
    end
  endfunction

  initial begin
    int unsigned win;
    int unsigned step;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // trackers off after reset: outputs stay zero
    send_tick(48'd0, 32'd0, 32'd0);
    send_tick(48'd1, '1, '1);

    // short window: start-up without trimming, trimming, out-of-order ticks
    set_config(1'b1, 32'd100, 1'b1, 1'b1);
    send_tick(48'd50, 32'd1000, 32'd2000);
    send_tick(48'd100, 32'd500, 32'd3000);
    send_tick(48'd150, 32'd700, 32'd1500);
    send_tick(48'd400, 32'd300, 32'd100);
    send_tick(48'd380, 32'd900, 32'd800);
    send_tick(48'd495, 32'd0, '1);

    // zero window keeps only ticks with the newest time
    set_config(1'b1, 32'd0, 1'b1, 1'b1);
    send_tick(48'd495, 32'd10, 32'd20);
    send_tick(48'd495, 32'd11, 32'd21);
    send_tick(48'd496, 32'd12, 32'd22);

    // widest window at the top of the time range, low tracker held
    set_config(1'b1, '1, 1'b1, 1'b0);
    send_tick('1, '1, 32'd0);
    send_tick('1, 32'd0, '1);
    send_tick(48'h0000_FFFF_FFFE, 32'd5, 32'd5);

    // window off, high tracker held
    set_config(1'b0, 32'd0, 1'b0, 1'b1);
    send_tick(48'h0001_0000_0000, 32'd1, 32'd1);
    send_tick(48'h8000_0000_0000, 32'd2, 32'd3);
    tape_ms = 48'h0000_0001_0000;

    // random segments, one setting each, idling pattern rotating
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0: begin
          win = $urandom_range(200, 2000);
          set_config(1'b1, win, 1'b1, 1'b1);
          step = win / 8;
        end
        1: begin
          set_config(1'b0, $urandom(), 1'b1, 1'b1);
          step = 50;
        end
        2: begin
          set_config(1'b1, 32'd0, 1'b1, 1'b0);
          step = 1;
        end
        3: begin
          set_config(1'b1, '1, 1'b0, 1'b1);
          tape_ms = TIME_W'({$urandom(), $urandom()});
          step = 1 << 20;
        end
        4: begin
          set_config(1'b1, $urandom(), 1'b1, 1'b1);
          tape_ms = TIME_W'({$urandom(), $urandom()});
          step = $urandom();
        end
        5: begin
          set_config(1'b1, 32'd1000, 1'b0, 1'b0);
          step = 100;
        end
        6: begin
          win = $urandom_range(10, 100);
          set_config(1'b1, win, 1'b1, 1'b1);
          step = 30;
        end
        default: begin
          set_config(1'b0, 32'd0, 1'b1, 1'b1);
          step = 1000;
        end
      endcase
      set_pace(pace_t'(s % 4));
      for (int n = 0; n < SEG_TICKS; n++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        advance_tape(step);
        send_tick(tape_ms, pick_price(), pick_price());
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    $display("covered %0d ticks under %0d register settings and four idling patterns",
             ticks_sent, settings_used);
    $display("%0d result words checked, %0d of them with an overflow drop",
             checked_words, drop_words);
    if (fault_count == 0 && open_words == 0)
      $display("tb_tick_window_high_low_unit: clean");
    else
      $display("tb_tick_window_high_low_unit: errors");
    $finish;
  end

endmodule
